// File: sv/qau_pkg.sv
// Package of the quaternion arithmetic unit: fixed point format, widths,
// operation and status codes, and the saturation helper.
// No dependencies.
package qau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int TW        = PW - FRAC_BITS;
    localparam int SW        = TW + 2;
    localparam int DVW       = SW + FRAC_BITS;
    localparam int QW        = DW;
    localparam int RW        = SW + 1;

    localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_LO = SW'(64'shFFFF_FFFF_8000_0000);
    localparam logic [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic                eq;
        logic                dz;
        logic                flag;
        logic [3:0]          neg;
        logic [3:0]          ovf;
        logic [3:0][DW-1:0]  res;
    } side_t;

    // {flag, value}: clamp to the signed 32-bit range
    function automatic logic [DW:0] sat_fn(input logic signed [SW-1:0] v);
        logic [DW:0] r;
        if (v > SAT_HI) begin
            r = {1'b1, S32_MAX};
        end else if (v < SAT_LO) begin
            r = {1'b1, S32_MIN};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

endpackage

// File: sv/qau_if.sv
// Valid/ready channels of the quaternion arithmetic unit: request and response.
// Depends on qau_pkg for the component width.
interface qau_req_if
    import qau_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [2:0]           req_type;
    logic signed [DW-1:0] a_x;
    logic signed [DW-1:0] a_y;
    logic signed [DW-1:0] a_z;
    logic signed [DW-1:0] a_w;
    logic signed [DW-1:0] b_x;
    logic signed [DW-1:0] b_y;
    logic signed [DW-1:0] b_z;
    logic signed [DW-1:0] b_w;

    modport source (output valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    input ready);
    modport sink   (input valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    output ready);
endinterface

interface qau_rsp_if
    import qau_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;
    logic signed [DW-1:0] r_z;
    logic signed [DW-1:0] r_w;
    logic                 is_equal;
    logic [1:0]           status;

    modport source (output valid, r_x, r_y, r_z, r_w, is_equal, status, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_w, is_equal, status, output ready);
endinterface

// File: sv/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit: add, subtract, Hamilton product, quotient, compare.
// Pipeline: 4 front stages, QW = 32 restoring-division stages and an output
// register; throughput one beat per cycle while not stalled, as the divider lanes are pipelined.
// The whole pipeline advances when the output register is empty or taken.
// rst_n (asynchronous, active low) clears all valid bits; payload is not reset.
// Depends on qau_pkg and qau_if.
module quaternion_arithmetic_unit
    import qau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qau_req_if.sink   req,
    qau_rsp_if.source rsp
);

    logic adv;

    logic signed [DW-1:0] a [4];
    logic signed [DW-1:0] b [4];

    // stage 1
    logic signed [PW-1:0] prod     [4][4];
    logic signed [PW-1:0] nprod    [4];
    logic signed [TW-1:0] p1_next  [4][4];
    logic signed [TW-1:0] p1_reg   [4][4];
    logic signed [TW-1:0] n1_next  [4];
    logic signed [TW-1:0] n1_reg   [4];
    logic signed [DW:0]   as1_next [4];
    logic signed [DW:0]   as1_reg  [4];
    op_t                  op1_next, op1_reg;
    logic                 eq1_next, eq1_reg;
    logic                 v1_reg;

    // stage 2
    logic signed [SW-1:0] e        [4][4];
    logic signed [SW-1:0] s2_next  [4];
    logic signed [SW-1:0] s2_reg   [4];
    logic [SW-1:0]        n2_next, n2_reg;
    op_t                  op2_reg;
    logic                 eq2_reg;
    logic                 v2_reg;

    // stage 3
    logic [DW-1:0]        res3_next [4];
    logic [DW-1:0]        res3_reg  [4];
    logic [SW-1:0]        mag3_next [4];
    logic [SW-1:0]        mag3_reg  [4];
    logic [3:0]           neg3_next, neg3_reg;
    logic                 flag3_next, flag3_reg;
    logic [SW-1:0]        n3_reg;
    logic                 dz3_next, dz3_reg;
    op_t                  op3_reg;
    logic                 eq3_reg;
    logic                 v3_reg;

    // divider pipeline, index 0 is the setup stage
    logic [RW-1:0]  rem_reg  [QW+1][4];
    logic [QW-1:0]  q_reg    [QW+1][4];
    logic [QW-1:0]  lo_reg   [QW+1][4];
    logic [SW-1:0]  n_reg    [QW+1];
    side_t          side_reg [QW+1];
    logic           v_reg    [QW+1];

    logic [RW-1:0]  rem_next [QW+1][4];
    logic [QW-1:0]  q_next   [QW+1][4];
    logic [QW-1:0]  lo_next  [QW+1][4];
    side_t          side0_next;

    // output register
    logic [DW-1:0]  r_next [4];
    logic [DW-1:0]  r_reg  [4];
    logic           eq_out_reg;
    status_t        st_next, st_reg;
    logic           vo_reg;

    assign adv       = !vo_reg || rsp.ready;
    assign req.ready = adv;

    assign a[0] = req.a_x;
    assign a[1] = req.a_y;
    assign a[2] = req.a_z;
    assign a[3] = req.a_w;
    assign b[0] = req.b_x;
    assign b[1] = req.b_y;
    assign b[2] = req.b_z;
    assign b[3] = req.b_w;

    // stage 1: products, add/sub, equality
    always_comb
    begin
        op1_next = op_t'(req.req_type);
        eq1_next = (req.a_x == req.b_x) && (req.a_y == req.b_y) &&
                   (req.a_z == req.b_z) && (req.a_w == req.b_w);
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod[i][j]    = PW'(a[i]) * PW'(b[j]);
                p1_next[i][j] = TW'(prod[i][j] >>> FRAC_BITS);
            end
            nprod[i]    = PW'(b[i]) * PW'(b[i]);
            n1_next[i]  = TW'(nprod[i] >>> FRAC_BITS);
            if (op1_next == OP_SUB)
            begin
                as1_next[i] = (DW+1)'(a[i]) - (DW+1)'(b[i]);
            end
            else
            begin
                as1_next[i] = (DW+1)'(a[i]) + (DW+1)'(b[i]);
            end
        end
    end

    // stage 2: sums of truncated products, or the add/sub result
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                e[i][j] = SW'(p1_reg[i][j]);
            end
        end
        n2_next = SW'(SW'(n1_reg[0]) + SW'(n1_reg[1]) + SW'(n1_reg[2]) + SW'(n1_reg[3]));
        case (op1_reg)
            OP_ADD, OP_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    s2_next[i] = SW'(as1_reg[i]);
                end
            end
            OP_MUL:
            begin
                s2_next[0] = e[3][0] + e[0][3] + e[1][2] - e[2][1];
                s2_next[1] = e[3][1] + e[1][3] + e[2][0] - e[0][2];
                s2_next[2] = e[3][2] + e[2][3] + e[0][1] - e[1][0];
                s2_next[3] = e[3][3] - e[0][0] - e[1][1] - e[2][2];
            end
            OP_DIV:
            begin
                s2_next[0] = e[0][3] - e[3][0] - e[1][2] + e[2][1];
                s2_next[1] = e[1][3] - e[3][1] - e[2][0] + e[0][2];
                s2_next[2] = e[2][3] - e[3][2] - e[0][1] + e[1][0];
                s2_next[3] = e[3][3] + e[0][0] + e[1][1] + e[2][2];
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    s2_next[i] = '0;
                end
            end
        endcase
    end

    // stage 3: saturate, or split sign and magnitude for the divider
    always_comb
    begin
        logic [DW:0] sr;
        flag3_next = 1'b0;
        dz3_next   = (n2_reg == '0);
        for (int i = 0; i < 4; i++)
        begin
            sr           = sat_fn(s2_reg[i]);
            res3_next[i] = sr[DW-1:0];
            flag3_next   = flag3_next | sr[DW];
            neg3_next[i] = s2_reg[i][SW-1];
            mag3_next[i] = s2_reg[i][SW-1] ? SW'(-s2_reg[i]) : SW'(s2_reg[i]);
        end
    end

    // stage 4: overflow test and remainder setup; then one quotient bit per stage
    always_comb
    begin
        logic [DVW-1:0] dvd;
        logic [RW-1:0]  t;
        side0_next.op   = op3_reg;
        side0_next.eq   = eq3_reg;
        side0_next.dz   = dz3_reg;
        side0_next.flag = flag3_reg;
        side0_next.neg  = neg3_reg;
        for (int i = 0; i < 4; i++)
        begin
            dvd                = {mag3_reg[i], {FRAC_BITS{1'b0}}};
            side0_next.ovf[i]  = DVW'(dvd[DVW-1:QW]) >= DVW'(n3_reg);
            side0_next.res[i]  = res3_reg[i];
            rem_next[0][i]     = RW'(dvd[DVW-1:QW]);
            lo_next[0][i]      = dvd[QW-1:0];
            q_next[0][i]       = '0;
        end
        for (int k = 0; k < QW; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t = {rem_reg[k][i][RW-2:0], lo_reg[k][i][QW-1]};
                if (t >= RW'(n_reg[k]))
                begin
                    rem_next[k+1][i] = t - RW'(n_reg[k]);
                    q_next[k+1][i]   = {q_reg[k][i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k+1][i] = t;
                    q_next[k+1][i]   = {q_reg[k][i][QW-2:0], 1'b0};
                end
                lo_next[k+1][i] = {lo_reg[k][i][QW-2:0], 1'b0};
            end
        end
    end

    // final: sign, saturation and result select
    always_comb
    begin
        side_t          sd;
        logic           fl;
        logic [QW-1:0]  q;
        sd = side_reg[QW];
        fl = 1'b0;
        q  = '0;
        st_next = ST_OK;
        for (int i = 0; i < 4; i++)
        begin
            r_next[i] = '0;
        end
        case (sd.op)
            OP_ADD, OP_SUB, OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    r_next[i] = sd.res[i];
                end
                if (sd.flag)
                begin
                    st_next = ST_SAT;
                end
            end
            OP_DIV:
            begin
                if (sd.dz)
                begin
                    st_next = ST_DIVZ;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        q = q_reg[QW][i];
                        if (sd.ovf[i])
                        begin
                            fl        = 1'b1;
                            r_next[i] = sd.neg[i] ? S32_MIN : S32_MAX;
                        end
                        else if (sd.neg[i])
                        begin
                            if (q > S32_MIN)
                            begin
                                fl        = 1'b1;
                                r_next[i] = S32_MIN;
                            end
                            else
                            begin
                                r_next[i] = DW'(-q);
                            end
                        end
                        else if (q[QW-1])
                        begin
                            fl        = 1'b1;
                            r_next[i] = S32_MAX;
                        end
                        else
                        begin
                            r_next[i] = DW'(q);
                        end
                    end
                    if (fl)
                    begin
                        st_next = ST_SAT;
                    end
                end
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg   <= req.valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v_reg[0] <= v3_reg;
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            vo_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg     <= p1_next;
            n1_reg     <= n1_next;
            as1_reg    <= as1_next;
            op1_reg    <= op1_next;
            eq1_reg    <= eq1_next;

            s2_reg     <= s2_next;
            n2_reg     <= n2_next;
            op2_reg    <= op1_reg;
            eq2_reg    <= eq1_reg;

            res3_reg   <= res3_next;
            mag3_reg   <= mag3_next;
            neg3_reg   <= neg3_next;
            flag3_reg  <= flag3_next;
            n3_reg     <= n2_reg;
            dz3_reg    <= dz3_next;
            op3_reg    <= op2_reg;
            eq3_reg    <= eq2_reg;

            side_reg[0] <= side0_next;
            n_reg[0]    <= n3_reg;
            for (int k = 0; k < QW; k++)
            begin
                side_reg[k+1] <= side_reg[k];
                n_reg[k+1]    <= n_reg[k];
            end
            rem_reg <= rem_next;
            q_reg   <= q_next;
            lo_reg  <= lo_next;

            r_reg      <= r_next;
            st_reg     <= st_next;
            eq_out_reg <= side_reg[QW].eq;
        end
    end

    assign rsp.valid    = vo_reg;
    assign rsp.r_x      = r_reg[0];
    assign rsp.r_y      = r_reg[1];
    assign rsp.r_z      = r_reg[2];
    assign rsp.r_w      = r_reg[3];
    assign rsp.is_equal = eq_out_reg;
    assign rsp.status   = st_reg;

endmodule
